>>> src/rat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region table allocator package
// Shared widths, codes and structures for the region table cells and top.
// ----------------------------------------------------------------------------
package rat_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int POOL_BYTES_DEF  = 4096;

    localparam int KIND_W   = 2;
    localparam int START_W  = 12;
    localparam int SIZE_W   = 13;
    localparam int LAST_W   = 14;
    localparam int STATUS_W = 3;

    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC = 2'd0,
        KIND_FREE  = 2'd1,
        KIND_CLEAR = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_GRANTED  = 3'd0,
        STAT_FULL     = 3'd1,
        STAT_OVERLAP  = 3'd2,
        STAT_BEYOND   = 3'd3,
        STAT_FREED    = 3'd4,
        STAT_NOTFOUND = 3'd5,
        STAT_CLEARED  = 3'd6
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EVAL = 1'b1
    } state_t;

    typedef struct packed {
        logic [START_W-1:0] start;
        logic [LAST_W-1:0]  last;
    } entry_t;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

    typedef struct packed {
        logic overlap;
        logic match;
    } cell_flags_t;

endpackage

>>> src/rat_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region table cell
// Holds one region, compares it against the current word, and loads either
// a new region or its upper neighbor's region when the table closes a gap.
// ----------------------------------------------------------------------------
module rat_cell (
    input  logic                clk,
    input  rat_pkg::cell_ctrl_t ctrl,
    input  rat_pkg::entry_t     cand,
    input  rat_pkg::entry_t     neighbor,
    output rat_pkg::entry_t     entry,
    output rat_pkg::cell_flags_t flags
);
    import rat_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.load)
        begin
            entry_next = cand;
        end
        else if (ctrl.shift)
        begin
            entry_next = neighbor;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry         = entry_reg;
    assign flags.match   = (entry_reg.start == cand.start);
    assign flags.overlap = (LAST_W'(entry_reg.start) <= cand.last) &&
                           (LAST_W'(cand.start) <= entry_reg.last);

endmodule

>>> src/region_table_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region table allocator
// Keeps a compact table of allocated (start, size) regions in a byte pool,
// grants non-overlapping allocations, frees by start offset, and clears.
// ----------------------------------------------------------------------------
// For each word, start is taken while busy is low, then busy is high
// for one evaluation cycle in which every cell of the table compares against
// the word at once and, on a free, the cells above the removed entry shift
// down by one. The result appears with done high for exactly one cycle, in
// the cycle after the evaluation cycle, and must be captured then since it
// cannot be held off. A new word can be started in that same cycle.
module region_table_allocator #(
    parameter int  MAX_ENTRIES = rat_pkg::MAX_ENTRIES_DEF,
    parameter int  POOL_BYTES  = rat_pkg::POOL_BYTES_DEF,
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [rat_pkg::KIND_W-1:0]    kind,
    input  logic [rat_pkg::START_W-1:0]   region_start,
    input  logic [rat_pkg::SIZE_W-1:0]    region_size,
    output logic                          done,
    output logic [rat_pkg::STATUS_W-1:0]  status,
    output logic [rat_pkg::START_W-1:0]   granted_start,
    output logic [CNT_W-1:0]              entries_in_use
);
    import rat_pkg::*;

    localparam int SUM_W = 18;
    localparam logic [SUM_W-1:0] POOL_LIM = SUM_W'(POOL_BYTES);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_ENTRIES);

    state_t                state_reg, state_next;
    logic [KIND_W-1:0]     cmd_kind_reg, cmd_kind_next;
    logic [START_W-1:0]    cmd_start_reg, cmd_start_next;
    logic [SIZE_W-1:0]     cmd_size_reg, cmd_size_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  done_reg, done_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [START_W-1:0]    granted_reg, granted_next;

    entry_t                cand;
    entry_t                cell_entry [MAX_ENTRIES];
    cell_flags_t           cell_flags [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] ovl_v;
    logic [MAX_ENTRIES:0]  seen;
    logic                  any_overlap;
    logic                  found;
    logic                  full;
    logic                  beyond;
    logic                  grant;
    logic                  free_do;
    logic [SUM_W-1:0]      end_sum;

    assign end_sum = SUM_W'(cmd_start_reg) + SUM_W'(cmd_size_reg);
    assign full    = (count_reg >= CNT_MAX);
    assign beyond  = (cmd_size_reg == '0) || (end_sum > POOL_LIM);

    assign cand.start = cmd_start_reg;
    assign cand.last  = LAST_W'(end_sum - SUM_W'(1));

    assign seen[0]     = 1'b0;
    assign any_overlap = |ovl_v;
    assign found       = seen[MAX_ENTRIES];

    assign grant   = (state_reg == S_EVAL) && (cmd_kind_reg == KIND_ALLOC) &&
                     !full && !beyond && !any_overlap;
    assign free_do = (state_reg == S_EVAL) && (cmd_kind_reg == KIND_FREE) && found;

    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        logic       occ;
        cell_ctrl_t ctrl;
        entry_t     nb;

        assign occ           = (CNT_W'(i) < count_reg);
        assign ovl_v[i]      = occ && cell_flags[i].overlap;
        assign seen[i + 1]   = seen[i] || (occ && cell_flags[i].match);
        assign ctrl.load     = grant && (count_reg == CNT_W'(i));
        assign ctrl.shift    = free_do && seen[i + 1];

        if (i == MAX_ENTRIES - 1)
        begin : g_last
            assign nb = cell_entry[i];
        end
        else
        begin : g_mid
            assign nb = cell_entry[i + 1];
        end

        rat_cell u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .cand     (cand),
            .neighbor (nb),
            .entry    (cell_entry[i]),
            .flags    (cell_flags[i])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_kind_next  = cmd_kind_reg;
        cmd_start_next = cmd_start_reg;
        cmd_size_next  = cmd_size_reg;
        count_next     = count_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        granted_next   = granted_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_kind_next  = kind;
                    cmd_start_next = region_start;
                    cmd_size_next  = region_size;
                    state_next     = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next   = S_IDLE;
                done_next    = 1'b1;
                granted_next = '0;
                case (cmd_kind_reg)
                    KIND_ALLOC:
                    begin
                        if (full)
                        begin
                            status_next = STAT_FULL;
                        end
                        else if (beyond)
                        begin
                            status_next = STAT_BEYOND;
                        end
                        else if (any_overlap)
                        begin
                            status_next = STAT_OVERLAP;
                        end
                        else
                        begin
                            status_next  = STAT_GRANTED;
                            granted_next = cmd_start_reg;
                            count_next   = count_reg + CNT_W'(1);
                        end
                    end
                    KIND_FREE:
                    begin
                        if (found)
                        begin
                            status_next = STAT_FREED;
                            count_next  = count_reg - CNT_W'(1);
                        end
                        else
                        begin
                            status_next = STAT_NOTFOUND;
                        end
                    end
                    KIND_CLEAR:
                    begin
                        status_next = STAT_CLEARED;
                        count_next  = '0;
                    end
                    default:
                    begin
                        status_next = STAT_NOTFOUND;
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_kind_reg  <= cmd_kind_next;
        cmd_start_reg <= cmd_start_next;
        cmd_size_reg  <= cmd_size_next;
        status_reg    <= status_next;
        granted_reg   <= granted_next;
    end

    assign busy           = (state_reg == S_EVAL);
    assign done           = done_reg;
    assign status         = status_reg;
    assign granted_start  = granted_reg;
    assign entries_in_use = count_reg;

endmodule
